@@ hw/rtl/usbh_pkg.sv @@
// ----------------------------------------------------------------------------
// USB host sequencer package
// Types, codes and constants shared by the enumeration and download sequencer.
// ----------------------------------------------------------------------------
package usbh_pkg;

  localparam int unsigned LenW   = 16;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [31:0] Signature    = 32'hCB00_C001;
  localparam logic [15:0] TxnInfoBytes = 16'd60;
  localparam logic [15:0] HeaderBytes  = 16'd128;
  localparam logic [15:0] DevDescBytes = 16'd18;
  localparam logic [15:0] CfgDescBytes = 16'd9;
  localparam logic [15:0] MinWordLen   = 16'd4;

  // Setup packet fields.
  localparam logic [7:0]  ReqTypeIn    = 8'h80;
  localparam logic [7:0]  ReqTypeOut   = 8'h00;
  localparam logic [7:0]  ReqGetDesc   = 8'd6;
  localparam logic [7:0]  ReqSetAddr   = 8'd5;
  localparam logic [7:0]  ReqSetConfig = 8'd9;
  localparam logic [15:0] DescDevice   = 16'h0100;
  localparam logic [15:0] DescConfig   = 16'h0200;
  localparam logic [15:0] DevAddress   = 16'd1;
  localparam logic [15:0] ConfigNumber = 16'd1;

  typedef enum logic [2:0] {
    ActDevReset = 3'd0,
    ActCtrlData = 3'd1,
    ActCtrlStat = 3'd2,
    ActBulkIn   = 3'd3,
    ActBulkOut  = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    KindSetup = 3'd0,
    KindTxn   = 3'd1,
    KindHdr   = 3'd2,
    KindRead  = 3'd3,
    KindNone  = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    EsIdle       = 3'd0,
    EsDevDesc    = 3'd1,
    EsSetAddr    = 3'd2,
    EsShortCfg   = 3'd3,
    EsFullCfg    = 3'd4,
    EsSetConfig  = 3'd5,
    EsConfigured = 3'd6
  } enum_step_e;

  typedef enum logic [2:0] {
    PhNone    = 3'd0,
    PhTxn     = 3'd1,
    PhHeader  = 3'd2,
    PhCatalog = 3'd3,
    PhPayload = 3'd4,
    PhDone    = 3'd5
  } phase_e;

  localparam logic [CfgIdxW-1:0] RegImageSize     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSegmentStride = 3'd1;
  localparam logic [CfgIdxW-1:0] RegCatalogOffset = 3'd2;
  localparam logic [CfgIdxW-1:0] RegCatalogLength = 3'd3;
  localparam logic [CfgIdxW-1:0] RegPayloadLength = 3'd4;

  typedef struct packed {
    logic [2:0]      action;
    logic [LenW-1:0] in_length;
    logic [31:0]     first_word;
    logic [LenW-1:0] out_space;
  } item_t;

  typedef struct packed {
    logic [31:0] catalog_offset;
    logic [31:0] catalog_length;
    logic [31:0] payload_length;
  } cfg_t;

  typedef struct packed {
    enum_step_e      enum_step;
    logic [LenW-1:0] cfg_total_len;
    phase_e          phase;
    logic [31:0]     cat_pos;
    logic [31:0]     cat_left;
    logic [31:0]     pay_pos;
    logic [31:0]     pay_left;
  } state_t;

  typedef struct packed {
    kind_e           kind;
    logic [7:0]      req_type;
    logic [7:0]      request;
    logic [15:0]     value;
    logic [15:0]     length;
    logic [31:0]     read_offset;
    logic [LenW-1:0] transfer_length;
    logic            enumerated;
    phase_e          phase;
  } result_t;

endpackage

@@ hw/rtl/usbh_in_stage.sv @@
// ----------------------------------------------------------------------------
// USB host sequencer input register
// Holds one bus event until the sequencer step takes it.
// ----------------------------------------------------------------------------
module usbh_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            stall_o,
  input  usbh_pkg::item_t item_i,
  input  logic            take_i,
  output logic            valid_o,
  output usbh_pkg::item_t item_o
);

  logic            valid_q;
  usbh_pkg::item_t item_q;

  // The register refills in the same cycle that its content is taken.
  assign stall_o = valid_q && !take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

@@ hw/rtl/usbh_step.sv @@
// ----------------------------------------------------------------------------
// USB host sequencer step logic
// Computes the response and the next sequencer state for one bus event.
// ----------------------------------------------------------------------------
module usbh_step (
  input  usbh_pkg::item_t   item_i,
  input  usbh_pkg::state_t  state_i,
  input  usbh_pkg::cfg_t    cfg_i,
  output usbh_pkg::state_t  state_o,
  output usbh_pkg::result_t result_o
);

  logic        do_status;
  logic        do_out;
  logic [15:0] cat_n;
  logic [15:0] pay_n;
  logic [31:0] cat_n_ext;
  logic [31:0] pay_n_ext;
  logic [31:0] cat_pos_next;

  // Chunk sizes: the free space capped at the bytes still to go.
  always_comb begin
    if (state_i.cat_left < {16'd0, item_i.out_space}) begin
      cat_n = state_i.cat_left[15:0];
    end else begin
      cat_n = item_i.out_space;
    end
    if (state_i.pay_left < {16'd0, item_i.out_space}) begin
      pay_n = state_i.pay_left[15:0];
    end else begin
      pay_n = item_i.out_space;
    end
  end

  assign cat_n_ext    = {16'd0, cat_n};
  assign pay_n_ext    = {16'd0, pay_n};
  assign cat_pos_next = state_i.cat_pos + cat_n_ext;

  always_comb begin
    state_o   = state_i;
    result_o  = '0;
    result_o.kind = usbh_pkg::KindNone;
    do_status = 1'b0;
    do_out    = 1'b0;

    case (item_i.action)
      usbh_pkg::ActDevReset: begin
        state_o.enum_step = usbh_pkg::EsDevDesc;
        state_o.phase     = usbh_pkg::PhNone;
        result_o.kind     = usbh_pkg::KindSetup;
        result_o.req_type = usbh_pkg::ReqTypeIn;
        result_o.request  = usbh_pkg::ReqGetDesc;
        result_o.value    = usbh_pkg::DescDevice;
        result_o.length   = usbh_pkg::DevDescBytes;
      end
      usbh_pkg::ActCtrlData: begin
        // An empty data stage closes the control transfer like a status stage.
        if (item_i.in_length == '0) begin
          do_status = 1'b1;
        end else if (state_i.enum_step == usbh_pkg::EsShortCfg &&
                     item_i.in_length >= usbh_pkg::MinWordLen) begin
          state_o.cfg_total_len = item_i.first_word[31:16];
        end
      end
      usbh_pkg::ActCtrlStat: begin
        do_status = 1'b1;
      end
      usbh_pkg::ActBulkIn: begin
        if (state_i.phase == usbh_pkg::PhNone &&
            item_i.in_length >= usbh_pkg::MinWordLen &&
            item_i.first_word == usbh_pkg::Signature) begin
          state_o.phase = usbh_pkg::PhTxn;
        end
      end
      usbh_pkg::ActBulkOut: begin
        do_out = 1'b1;
      end
      default: begin
      end
    endcase

    if (do_status) begin
      case (state_i.enum_step)
        usbh_pkg::EsDevDesc: begin
          state_o.enum_step = usbh_pkg::EsSetAddr;
          result_o.kind     = usbh_pkg::KindSetup;
          result_o.req_type = usbh_pkg::ReqTypeOut;
          result_o.request  = usbh_pkg::ReqSetAddr;
          result_o.value    = usbh_pkg::DevAddress;
        end
        usbh_pkg::EsSetAddr: begin
          state_o.enum_step = usbh_pkg::EsShortCfg;
          result_o.kind     = usbh_pkg::KindSetup;
          result_o.req_type = usbh_pkg::ReqTypeIn;
          result_o.request  = usbh_pkg::ReqGetDesc;
          result_o.value    = usbh_pkg::DescConfig;
          result_o.length   = usbh_pkg::CfgDescBytes;
        end
        usbh_pkg::EsShortCfg: begin
          state_o.enum_step = usbh_pkg::EsFullCfg;
          result_o.kind     = usbh_pkg::KindSetup;
          result_o.req_type = usbh_pkg::ReqTypeIn;
          result_o.request  = usbh_pkg::ReqGetDesc;
          result_o.value    = usbh_pkg::DescConfig;
          result_o.length   = state_i.cfg_total_len;
        end
        usbh_pkg::EsFullCfg: begin
          state_o.enum_step = usbh_pkg::EsSetConfig;
          result_o.kind     = usbh_pkg::KindSetup;
          result_o.req_type = usbh_pkg::ReqTypeOut;
          result_o.request  = usbh_pkg::ReqSetConfig;
          result_o.value    = usbh_pkg::ConfigNumber;
        end
        usbh_pkg::EsSetConfig: begin
          state_o.enum_step = usbh_pkg::EsConfigured;
        end
        default: begin
        end
      endcase
    end

    if (do_out) begin
      case (state_i.phase)
        usbh_pkg::PhTxn: begin
          if (item_i.out_space >= usbh_pkg::TxnInfoBytes) begin
            result_o.kind            = usbh_pkg::KindTxn;
            result_o.transfer_length = usbh_pkg::TxnInfoBytes;
            state_o.phase            = usbh_pkg::PhHeader;
          end
        end
        usbh_pkg::PhHeader: begin
          if (item_i.out_space >= usbh_pkg::HeaderBytes) begin
            result_o.kind            = usbh_pkg::KindHdr;
            result_o.transfer_length = usbh_pkg::HeaderBytes;
            state_o.cat_pos  = cfg_i.catalog_offset;
            state_o.cat_left = cfg_i.catalog_length;
            state_o.pay_left = cfg_i.payload_length;
            state_o.pay_pos  = cfg_i.catalog_offset + cfg_i.catalog_length;
            state_o.phase    = usbh_pkg::PhCatalog;
          end
        end
        usbh_pkg::PhCatalog: begin
          if (state_i.cat_left == '0) begin
            state_o.pay_pos = state_i.cat_pos;
            state_o.phase   = usbh_pkg::PhPayload;
          end else if (cat_n != '0) begin
            result_o.kind            = usbh_pkg::KindRead;
            result_o.read_offset     = state_i.cat_pos;
            result_o.transfer_length = cat_n;
            state_o.cat_pos  = cat_pos_next;
            state_o.cat_left = state_i.cat_left - cat_n_ext;
            // The payload follows right after the last catalog byte read.
            if (state_i.cat_left == cat_n_ext) begin
              state_o.pay_pos = cat_pos_next;
              state_o.phase   = usbh_pkg::PhPayload;
            end
          end
        end
        usbh_pkg::PhPayload: begin
          if (state_i.pay_left == '0) begin
            state_o.phase = usbh_pkg::PhDone;
          end else if (pay_n != '0) begin
            result_o.kind            = usbh_pkg::KindRead;
            result_o.read_offset     = state_i.pay_pos;
            result_o.transfer_length = pay_n;
            state_o.pay_pos  = state_i.pay_pos + pay_n_ext;
            state_o.pay_left = state_i.pay_left - pay_n_ext;
            if (state_i.pay_left == pay_n_ext) begin
              state_o.phase = usbh_pkg::PhDone;
            end
          end
        end
        default: begin
        end
      endcase
    end

    result_o.enumerated = (state_o.enum_step == usbh_pkg::EsConfigured);
    result_o.phase      = state_o.phase;
  end

endmodule

@@ hw/rtl/usb_host_enum_and_download_sequencer.sv @@
// ----------------------------------------------------------------------------
// USB host enumeration and download sequencer
// Turns bus events into setup requests and bulk-out image transfers.
// ----------------------------------------------------------------------------
// Each input request is one bus event (device reset, control data or status
// stage, bulk-in packet, bulk-out slot). Each event yields exactly one
// response on the output channel, which may be of kind "nothing sent".
// Both channels use valid and stall; a request moves when valid is high and
// stall is low.
// The event is captured in an input register, the step logic computes the
// response and the next sequencer state combinationally, and the response is
// registered: it is offered from the output register once the step has taken it.
// Throughput is one event per cycle whenever the receiver does not stall.
// While the receiver stalls, the response holds; one further event waits in
// the input register, and the input stall rises only when both are full.
// The user must write configuration registers via the write port only while
// no event is in flight; the block does not enforce it. Reset clears the
// enumeration step, download phase, all counters and configuration registers.
// ----------------------------------------------------------------------------
module usb_host_enum_and_download_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  action_i,
  input  logic [15:0] in_length_i,
  input  logic [31:0] first_word_i,
  input  logic [15:0] out_space_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  result_kind_o,
  output logic [7:0]  setup_request_type_o,
  output logic [7:0]  setup_request_o,
  output logic [15:0] setup_value_o,
  output logic [15:0] setup_length_o,
  output logic [31:0] read_offset_o,
  output logic [15:0] transfer_length_o,
  output logic        enumerated_o,
  output logic [2:0]  download_phase_o
);

  usbh_pkg::item_t   in_item;
  usbh_pkg::item_t   item;
  logic              item_valid;
  logic              advance;
  logic              fire;
  usbh_pkg::cfg_t    cfg_q;
  usbh_pkg::state_t  state_q;
  usbh_pkg::state_t  state_d;
  usbh_pkg::result_t res_d;
  usbh_pkg::result_t res_q;
  logic              out_valid_q;

  assign in_item.action     = action_i;
  assign in_item.in_length  = in_length_i;
  assign in_item.first_word = first_word_i;
  assign in_item.out_space  = out_space_i;

  // The output register takes a new response when empty or being drained.
  assign advance = !out_valid_q || !out_stall_i;
  assign fire    = item_valid && advance;

  usbh_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .item_i  (in_item),
    .take_i  (advance),
    .valid_o (item_valid),
    .item_o  (item)
  );

  usbh_step u_step (
    .item_i   (item),
    .state_i  (state_q),
    .cfg_i    (cfg_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // Image size and segment stride do not affect any response.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        usbh_pkg::RegCatalogOffset: cfg_q.catalog_offset <= cfg_data_i;
        usbh_pkg::RegCatalogLength: cfg_q.catalog_length <= cfg_data_i;
        usbh_pkg::RegPayloadLength: cfg_q.payload_length <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (fire) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= item_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign result_kind_o        = res_q.kind;
  assign setup_request_type_o = res_q.req_type;
  assign setup_request_o      = res_q.request;
  assign setup_value_o        = res_q.value;
  assign setup_length_o       = res_q.length;
  assign read_offset_o        = res_q.read_offset;
  assign transfer_length_o    = res_q.transfer_length;
  assign enumerated_o         = res_q.enumerated;
  assign download_phase_o     = res_q.phase;

  a_setup_fields_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.kind != usbh_pkg::KindSetup |->
      res_q.req_type == '0 && res_q.request == '0 && res_q.value == '0 &&
      res_q.length == '0)
    else $error("setup fields set on a non-setup response");

  a_offset_only_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.kind != usbh_pkg::KindHdr && res_q.kind != usbh_pkg::KindRead |->
      res_q.read_offset == '0)
    else $error("read offset set on a response that reads nothing");

  a_txn_then_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.kind == usbh_pkg::KindTxn |->
      res_q.phase == usbh_pkg::PhHeader && res_q.transfer_length == usbh_pkg::TxnInfoBytes)
    else $error("transaction info response with wrong phase or length");

  a_header_then_catalog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.kind == usbh_pkg::KindHdr |->
      res_q.phase == usbh_pkg::PhCatalog && res_q.transfer_length == usbh_pkg::HeaderBytes)
    else $error("header response with wrong phase or length");

  a_fire_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("event taken without a response");

endmodule
